### src/pse_pkg.sv
// shared types, codes and saturation helper for the postfix stack evaluator
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

  // token codes
  localparam logic [2:0] FN_PUSH = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SUB  = 3'd2;
  localparam logic [2:0] FN_MUL  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNDER   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  // divider: one quotient bit per step over a 48-bit scaled dividend
  localparam int          DIV_STEPS = 48;
  localparam int          DIV_CW    = 6;
  localparam logic [5:0]  DIV_LAST  = 6'(DIV_STEPS - 1);

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] operand_value;
  } pse_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [7:0]         stack_depth;
  } pse_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic push;
    logic capture;
    logic mul_fin;
    logic div_step;
    logic div_fin;
    logic write_res;
  } pse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       full;
    logic       lt2;
    logic       right_zero;
    logic       div_done;
  } pse_stat_t;

  // clamp a wide signed value to the q16.16 range
  function automatic logic signed [31:0] sat_q16(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sh0_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -49'sh0_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/pse_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/pse_datapath.sv
// stack storage, depth counter, top register and arithmetic units
`timescale 1ns / 1ps
`default_nettype none

module pse_datapath
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire pse_in_t      in_item,
  input  wire pse_cmd_t     cmd,
  output pse_stat_t         dp_st,
  output logic signed [31:0] top_value,
  output logic [7:0]        stack_depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [2:0]         func_r;
  logic signed [31:0] opnd_r;
  logic [DW-1:0]      depth_r;
  logic signed [31:0] top_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] result_r;
  logic               neg_r;
  logic [31:0]        dvs_r;
  logic [31:0]        rem_r;
  logic [47:0]        quo_r;
  logic [DIV_CW-1:0]  cnt_r;

  logic [DW-1:0]      depth_m2;
  logic [AW-1:0]      left_idx;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic [31:0]        ram_rdata;
  logic signed [31:0] left_s;
  logic signed [32:0] sum_nxt;
  logic signed [63:0] prod_nxt;
  logic signed [47:0] mulq;
  logic signed [47:0] mulq_nxt;
  logic [31:0]        left_mag;
  logic [31:0]        right_mag;
  logic [32:0]        shifted;
  logic [33:0]        diff;
  logic               ge;
  logic [31:0]        rem_nxt;
  logic signed [48:0] quo_s;
  logic signed [48:0] divq_nxt;
  logic [DW+7:0]      depth_ext;

  // stack memory: push writes at depth, operators read and write at depth-2
  assign depth_m2  = depth_r - DW'(2);
  assign left_idx  = depth_m2[AW-1:0];
  assign ram_we    = cmd.push | cmd.write_res;
  assign ram_waddr = cmd.push ? depth_r[AW-1:0] : left_idx;
  assign ram_wdata = cmd.push ? opnd_r : result_r;

  pse_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (left_idx),
    .rdata (ram_rdata)
  );

  // add / subtract with one guard bit
  assign left_s  = ram_rdata;
  assign sum_nxt = (func_r == FN_SUB) ? ({left_s[31], left_s} - {top_r[31], top_r})
                                      : ({left_s[31], left_s} + {top_r[31], top_r});

  // multiply, then shift right by 16 rounding toward zero
  assign prod_nxt = left_s * top_r;
  assign mulq     = prod_r[63:16];
  assign mulq_nxt = (prod_r[63] && (prod_r[15:0] != 16'd0)) ? (mulq + 48'sd1) : mulq;

  // operand magnitudes for the divider
  assign left_mag  = left_s[31] ? (32'd0 - left_s) : left_s;
  assign right_mag = top_r[31] ? (32'd0 - top_r) : top_r;

  // one restoring division step
  assign shifted = {rem_r, quo_r[47]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign ge      = ~diff[33];
  assign rem_nxt = ge ? diff[31:0] : shifted[31:0];

  // signed quotient
  assign quo_s    = {1'b0, quo_r};
  assign divq_nxt = neg_r ? (49'sd0 - quo_s) : quo_s;

  // token latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_item.func;
      opnd_r <= in_item.operand_value;
    end
  end

  // depth counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.push) begin
      depth_r <= depth_r + DW'(1);
    end else if (cmd.write_res) begin
      depth_r <= depth_r - DW'(1);
    end
  end

  // cached top of stack
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_r <= opnd_r;
    end else if (cmd.write_res) begin
      top_r <= result_r;
    end
  end

  // operand capture and result finish
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prod_r   <= prod_nxt;
      result_r <= sat_q16({{16{sum_nxt[32]}}, sum_nxt});
      neg_r    <= left_s[31] ^ top_r[31];
      dvs_r    <= right_mag;
      quo_r    <= {left_mag, 16'd0};
      rem_r    <= '0;
    end else begin
      if (cmd.mul_fin) begin
        result_r <= sat_q16({mulq_nxt[47], mulq_nxt});
      end
      if (cmd.div_fin) begin
        result_r <= sat_q16(divq_nxt);
      end
      if (cmd.div_step) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[46:0], ge};
      end
    end
  end

  // divider step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.capture) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + DIV_CW'(1);
    end
  end

  // status toward the controller
  assign dp_st.func       = func_r;
  assign dp_st.full       = (depth_r >= DW'(STACK_DEPTH));
  assign dp_st.lt2        = (depth_r < DW'(2));
  assign dp_st.right_zero = (top_r == 32'sd0);
  assign dp_st.div_done   = (cnt_r == DIV_LAST);

  // result fields
  assign depth_ext   = {8'd0, depth_r};
  assign stack_depth = depth_ext[7:0];
  assign top_value   = (depth_r != '0) ? top_r : 32'sd0;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !dp_st.full)
    else $error("push issued on a full stack");
  a_write_two: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_res |-> !dp_st.lt2)
    else $error("operator result written with fewer than two entries");
`endif

endmodule

`default_nettype wire

### src/pse_ctrl.sv
// controller state machine: sequences one token through the datapath
`timescale 1ns / 1ps
`default_nettype none

module pse_ctrl
  import pse_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire pse_stat_t dp_st,
  output pse_cmd_t       cmd,
  output logic [1:0]     status
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_MULF  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_DIVF  = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] status_r, status_nxt;
  logic       is_op;

  assign is_op = dp_st.func inside {FN_ADD, FN_SUB, FN_MUL, FN_DIV};

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
        if (dp_st.func == FN_PUSH) begin
          if (dp_st.full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (is_op) begin
          if (dp_st.lt2) begin
            status_nxt = ST_UNDER;
          end else if (dp_st.func == FN_DIV && dp_st.right_zero) begin
            status_nxt = ST_DIVZERO;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.capture = 1'b1;
        if (dp_st.func == FN_MUL) begin
          state_nxt = S_MULF;
        end else if (dp_st.func == FN_DIV) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_MULF: begin
        cmd.mul_fin = 1'b1;
        state_nxt   = S_WRITE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (dp_st.div_done) begin
          state_nxt = S_DIVF;
        end
      end
      S_DIVF: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_res = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);
  assign status    = status_r;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("new item taken while a result is pending");
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && dp_st.div_done) |=> (state_r == S_DIVF))
    else $error("divider did not finish after its last step");
  a_write_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_res |=> out_valid)
    else $error("operator result not presented after write");
`endif

endmodule

`default_nettype wire

### src/postfix_stack_evaluator.sv
// top level of the reverse polish q16.16 stack evaluator
// after decode, push, ignored codes and errors go straight to the result; add/subtract
// read the stack, then write the result; multiply adds a finish step before the write;
// divide runs the bit-serial divider loop, then a finish step and the write;
// one item is in flight at a time, the divider loop sets the worst case
// reset (rst_n low, synchronous) empties the stack and returns the controller to idle;
// stack memory contents are not cleared, entries are written before they are read
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_evaluator
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire pse_in_t in_item,
  output logic         out_valid,
  input  wire logic    out_stall,
  output pse_out_t     out_item
);

  pse_cmd_t           cmd;
  pse_stat_t          dp_st;
  logic [1:0]         status;
  logic signed [31:0] top_value;
  logic [7:0]         stack_depth;

  // sequencer
  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_st     (dp_st),
    .cmd       (cmd),
    .status    (status)
  );

  // stack and arithmetic
  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cmd         (cmd),
    .dp_st       (dp_st),
    .top_value   (top_value),
    .stack_depth (stack_depth)
  );

  // result item
  assign out_item.status      = status;
  assign out_item.top_value   = top_value;
  assign out_item.stack_depth = stack_depth;

endmodule

`default_nettype wire

### test/postfix_stack_evaluator_test.sv
// self-checking testbench for the postfix stack evaluator: directed and random token streams
`timescale 1ns / 1ps

import pse_pkg::*;

// expected-result tracker: keeps its own operand stack and compares each result item
class eval_scoreboard;
  logic signed [31:0] stk[];
  int                 cap;
  int                 depth;
  int                 max_depth;
  pse_out_t           expected_q[$];
  int                 mismatches;
  int                 results_seen;
  int                 status_seen[4];
  int                 pushes;
  int                 operators;
  int                 spares;

  function new(int stack_cap);
    cap          = stack_cap;
    stk          = new[stack_cap];
    depth        = 0;
    max_depth    = 0;
    mismatches   = 0;
    results_seen = 0;
    pushes       = 0;
    operators    = 0;
    spares       = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  // clamp a wide intermediate to the q16.16 range
  function logic signed [31:0] clamp_q16(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // apply one accepted token to the stack copy and queue the result it should give
  function void note_token(pse_in_t tok);
    logic signed [63:0] lhs;
    logic signed [63:0] rhs;
    logic signed [63:0] res;
    logic [1:0]         st;
    logic               ok;
    pse_out_t           want;
    st  = ST_OK;
    res = '0;
    case (tok.func)
      FN_PUSH: begin
        pushes++;
        if (depth >= cap) begin
          st = ST_FULL;
        end else begin
          stk[depth] = tok.operand_value;
          depth++;
        end
      end
      FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
        operators++;
        if (depth < 2) begin
          st = ST_UNDER;
        end else begin
          rhs = 64'(stk[depth-1]);
          lhs = 64'(stk[depth-2]);
          ok  = 1'b1;
          case (tok.func)
            FN_ADD: res = lhs + rhs;
            FN_SUB: res = lhs - rhs;
            FN_MUL: res = (lhs * rhs) / 64'sd65536;
            default: begin
              if (rhs == 0) ok = 1'b0;
              else res = (lhs * 64'sd65536) / rhs;
            end
          endcase
          if (ok) begin
            stk[depth-2] = clamp_q16(res);
            depth--;
          end else begin
            st = ST_DIVZERO;
          end
        end
      end
      default: spares++;
    endcase
    if (depth > max_depth) max_depth = depth;
    want.status      = st;
    want.top_value   = (depth > 0) ? stk[depth-1] : 32'sd0;
    want.stack_depth = depth[7:0];
    expected_q.push_back(want);
  endfunction

  // compare one result item with the oldest expectation
  function void check_result(pse_out_t got);
    pse_out_t want;
    results_seen++;
    status_seen[got.status]++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result with nothing expected: status %0d top %h depth %0d",
                 got.status, got.top_value, got.stack_depth);
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status || got.top_value !== want.top_value ||
        got.stack_depth !== want.stack_depth) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"ERROR: result %0d: expected status %0d top %h depth %0d, ",
                  "got status %0d top %h depth %0d"},
                 results_seen, want.status, want.top_value, want.stack_depth,
                 got.status, got.top_value, got.stack_depth);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module postfix_stack_evaluator_test;
  localparam int STACK_DEPTH   = 128;
  localparam int MAX_WAIT      = 18;
  localparam int RANDOM_ITEMS  = 1520;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 64;

  // func codes the block ignores
  localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FN_SPARE_LAST  = 3'd7;

  // burst flavors of the random token stream
  localparam int MODE_MIX    = 0;
  localparam int MODE_GROW   = 1;
  localparam int MODE_SHRINK = 2;

  // q16.16 constants for the directed part
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ZERO  = 32'sh0000_0000;
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] Q_THREE = 32'sh0003_0000;
  localparam logic signed [31:0] Q_M_ONE = 32'shFFFF_0000;
  localparam logic signed [31:0] Q_M_TWO = 32'shFFFE_0000;
  localparam logic signed [31:0] Q_HALF  = 32'sh0000_8000;
  localparam logic signed [31:0] Q_LSB   = 32'sh0000_0001;
  localparam logic signed [31:0] Q_M_LSB = 32'shFFFF_FFFF;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pse_in_t  in_item;
  logic     out_valid;
  logic     out_stall;
  pse_out_t out_item;

  eval_scoreboard sb;
  int             cycle_count = 0;
  bit             sender_gaps_on;

  postfix_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // present one token, after a random gap when sender gaps are on, and wait until it is taken
  task automatic send_token(logic [2:0] fn, logic signed [31:0] val);
    int      gap;
    pse_in_t tok;
    tok.func          = fn;
    tok.operand_value = val;
    gap = sender_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= tok;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_token(tok);
  endtask

  // hold off the sender until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // operand mix: zeros for divide by zero, extremes, small values, full-range noise
  function automatic logic signed [31:0] rand_operand();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = Q_ZERO;
      1: begin
        case ($urandom_range(0, 3))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = Q_LSB;
          default: v = Q_M_LSB;
        endcase
      end
      2, 3, 4, 5: begin
        v = $urandom_range(0, 32'h0010_0000);
        v = v - 32'sh0008_0000;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // corner cases of every operation, the underflow and divide by zero statuses and ignored codes
  task automatic directed_phase();
    send_token(FN_ADD, $urandom);       // operator on empty stack
    send_token(FN_PUSH, Q_MAX);
    send_token(FN_DIV, $urandom);       // operator with one entry
    send_token(FN_PUSH, Q_MAX);
    send_token(FN_ADD, $urandom);       // sum saturates high
    send_token(FN_PUSH, Q_MIN);
    send_token(FN_SUB, $urandom);       // difference saturates high
    send_token(FN_PUSH, Q_MIN);
    send_token(FN_MUL, $urandom);       // product saturates low
    send_token(FN_PUSH, Q_ZERO);
    send_token(FN_DIV, $urandom);       // divide by zero
    send_token(FN_SPARE_FIRST, Q_M_LSB);
    send_token(FN_SPARE_LAST, Q_ZERO);
    send_token(FN_SUB, $urandom);
    send_token(FN_PUSH, Q_M_ONE);
    send_token(FN_DIV, $urandom);       // most negative over minus one saturates high
    send_token(FN_PUSH, Q_ONE);
    send_token(FN_PUSH, Q_THREE);
    send_token(FN_DIV, $urandom);       // quotient truncated
    send_token(FN_PUSH, Q_M_TWO);
    send_token(FN_DIV, $urandom);       // negative quotient truncates toward zero
    send_token(FN_PUSH, Q_LSB);
    send_token(FN_DIV, $urandom);
    send_token(FN_PUSH, Q_M_LSB);
    send_token(FN_PUSH, Q_HALF);
    send_token(FN_MUL, $urandom);       // negative product truncates to zero
    send_token(FN_ADD, $urandom);
    send_token(FN_SUB, $urandom);
    send_token(FN_SUB, $urandom);
  endtask

  // bursts that fill, churn or empty the stack, with random content
  task automatic random_phase();
    int         sent;
    int         burst_left;
    int         mode;
    int         push_pct;
    logic [2:0] fn;
    sent       = 0;
    burst_left = 0;
    mode       = MODE_GROW;
    while (sent < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        if (sent > 0 && $urandom_range(0, 5) == 0) drain_results();
        if (sent == 0) begin
          // first burst runs the stack into its full state
          mode       = MODE_GROW;
          burst_left = 200;
        end else begin
          mode       = $urandom_range(MODE_MIX, MODE_SHRINK);
          burst_left = (mode == MODE_GROW) ? $urandom_range(120, 200)
                                           : $urandom_range(10, 60);
        end
        sender_gaps_on = ($urandom_range(0, 2) != 0);
      end
      push_pct = (mode == MODE_GROW) ? 90 : (mode == MODE_SHRINK) ? 25 : 55;
      if ($urandom_range(0, 99) < 3) fn = 3'($urandom_range(FN_SPARE_LAST, FN_SPARE_FIRST));
      else if ($urandom_range(0, 99) < push_pct) fn = FN_PUSH;
      else fn = 3'($urandom_range(FN_DIV, FN_ADD));
      send_token(fn, rand_operand());
      sent++;
      burst_left--;
    end
  endtask

  // result side: random stalls in stretches, every accepted item is checked
  initial begin : result_sink
    int wait_cycles;
    int stretch;
    bit stalls_on;
    out_stall <= 1'b0;
    stretch   = 0;
    stalls_on = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      if (stretch == 0) begin
        stalls_on = ($urandom_range(0, 2) != 0);
        stretch   = $urandom_range(20, 80);
      end
      stretch--;
      wait_cycles = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_result(out_item);
    end
  end

  // main sequence
  initial begin
    sb             = new(STACK_DEPTH);
    sender_gaps_on = 1'b1;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    directed_phase();
    drain_results();
    random_phase();
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pushes, %0d operators, %0d ignored codes; deepest stack %0d of %0d",
             sb.pushes, sb.operators, sb.spares, sb.max_depth, STACK_DEPTH);
    $display({"results checked %0d: ok %0d, underflow %0d, full %0d, ",
              "divide by zero %0d, mismatches %0d"},
             sb.results_seen, sb.status_seen[ST_OK], sb.status_seen[ST_UNDER],
             sb.status_seen[ST_FULL], sb.status_seen[ST_DIVZERO], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
